/* hw/rtl/bgc_pkg.sv */
// Shared types and constants for the button gesture classifier.
// Used by every module under hw/rtl; depends on nothing else.
package bgc_pkg;

  localparam int BUTTONS     = 2;
  localparam int LEVEL_W     = BUTTONS;
  localparam int BTN_W       = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam int KIND_W      = 3;
  localparam int NSLOT       = 3 * BUTTONS;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int HOLD_W      = 16;
  localparam int DEB_W       = 8;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_EDGE = 1'b1;

  localparam logic [KIND_W-1:0] EV_SHORT       = 3'd0;
  localparam logic [KIND_W-1:0] EV_DOUBLE      = 3'd1;
  localparam logic [KIND_W-1:0] EV_LONG_HOLD   = 3'd2;
  localparam logic [KIND_W-1:0] EV_LONG_PRESS  = 3'd3;
  localparam logic [KIND_W-1:0] EV_VLONG_HOLD  = 3'd4;
  localparam logic [KIND_W-1:0] EV_VLONG_PRESS = 3'd5;

  localparam logic [HOLD_W-1:0] LONG_HOLD_RESET     = 16'd200;
  localparam logic [HOLD_W-1:0] VLONG_EXTRA_RESET   = 16'd300;
  localparam logic [HOLD_W-1:0] DOUBLE_WINDOW_RESET = 16'd100;
  localparam logic [DEB_W-1:0]  DEBOUNCE_RESET      = 8'd3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LONG_HOLD     = 2'd0,
    REG_VLONG_EXTRA   = 2'd1,
    REG_DOUBLE_WINDOW = 2'd2,
    REG_DEBOUNCE      = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic               cmd;
    logic [LEVEL_W-1:0] pin_levels;
  } in_item_t;

  typedef struct packed {
    logic [BTN_W-1:0]  button_index;
    logic [KIND_W-1:0] event_kind;
    logic              last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [HOLD_W-1:0] long_hold_ticks;
    logic [HOLD_W-1:0] very_long_extra_ticks;
    logic [HOLD_W-1:0] double_window_ticks;
    logic [DEB_W-1:0]  debounce_ticks;
  } cfg_t;

  // Events one button can raise for one tick, in report order.
  typedef struct packed {
    logic              hold_ev;
    logic [KIND_W-1:0] hold_kind;
    logic              win_ev;
    logic              rel_ev;
    logic [KIND_W-1:0] rel_kind;
  } btn_ev_t;

endpackage

/* hw/rtl/bgc_cfg_regs.sv */
// Configuration register file of the gesture classifier.
// Depends on bgc_pkg for the register indexes and the cfg_t bundle.
module bgc_cfg_regs
  import bgc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_hold_ticks       <= LONG_HOLD_RESET;
      cfg.very_long_extra_ticks <= VLONG_EXTRA_RESET;
      cfg.double_window_ticks   <= DOUBLE_WINDOW_RESET;
      cfg.debounce_ticks        <= DEBOUNCE_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_LONG_HOLD:     cfg.long_hold_ticks       <= cfg_data;
        REG_VLONG_EXTRA:   cfg.very_long_extra_ticks <= cfg_data;
        REG_DOUBLE_WINDOW: cfg.double_window_ticks   <= cfg_data;
        REG_DEBOUNCE:      cfg.debounce_ticks        <= cfg_data[DEB_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

/* hw/rtl/bgc_button.sv */
// Per-button gesture state: press phase, double flag, hold and window countdowns.
// Depends on bgc_pkg for cfg_t, btn_ev_t and the event codes.
module bgc_button
  import bgc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    tick,
  input  logic    chg,
  input  logic    lvl,
  input  cfg_t    cfg,
  output btn_ev_t ev
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SHORT = 2'd1,
    PH_LONG  = 2'd2,
    PH_VLONG = 2'd3
  } phase_t;

  phase_t            phase, phase_next;
  logic              pend, pend_next;
  logic [HOLD_W-1:0] hold_cnt, hold_cnt_next;
  logic [HOLD_W-1:0] win_cnt, win_cnt_next;

  logic [HOLD_W-1:0] hold_dec, win_dec;
  logic              hold_exp, win_exp;

  assign hold_dec = hold_cnt - 1'b1;
  assign win_dec  = win_cnt - 1'b1;
  assign hold_exp = (hold_cnt != '0) && (hold_dec == '0);
  assign win_exp  = (win_cnt != '0) && (win_dec == '0);

  // Timer expiries are applied first, then the confirmed pin change sees their result.
  always_comb begin
    phase_next    = phase;
    pend_next     = pend;
    hold_cnt_next = hold_cnt;
    win_cnt_next  = win_cnt;
    ev            = '0;
    ev.hold_kind  = EV_LONG_HOLD;
    ev.rel_kind   = EV_LONG_PRESS;
    if (tick) begin
      if (hold_cnt != '0) begin
        hold_cnt_next = hold_dec;
      end
      if (win_cnt != '0) begin
        win_cnt_next = win_dec;
      end
      if (hold_exp) begin
        if (phase == PH_SHORT) begin
          ev.hold_ev    = 1'b1;
          ev.hold_kind  = EV_LONG_HOLD;
          hold_cnt_next = cfg.very_long_extra_ticks;
          phase_next    = PH_LONG;
        end else if (phase == PH_LONG) begin
          ev.hold_ev   = 1'b1;
          ev.hold_kind = EV_VLONG_HOLD;
          phase_next   = PH_VLONG;
        end
      end
      if (win_exp) begin
        ev.win_ev    = 1'b1;
        pend_next    = 1'b0;
        phase_next   = PH_IDLE;
        win_cnt_next = '0;
      end
      if (chg) begin
        hold_cnt_next = '0;
        if (!lvl) begin
          if (phase_next != PH_SHORT) begin
            phase_next    = PH_SHORT;
            hold_cnt_next = cfg.long_hold_ticks;
          end
        end else begin
          case (phase_next)
            PH_SHORT: begin
              if (!pend_next) begin
                pend_next    = 1'b1;
                win_cnt_next = cfg.double_window_ticks;
              end else begin
                pend_next    = 1'b0;
                win_cnt_next = '0;
                ev.rel_ev    = 1'b1;
                ev.rel_kind  = EV_DOUBLE;
              end
            end
            PH_LONG: begin
              ev.rel_ev   = 1'b1;
              ev.rel_kind = EV_LONG_PRESS;
            end
            PH_VLONG: begin
              ev.rel_ev   = 1'b1;
              ev.rel_kind = EV_VLONG_PRESS;
            end
            default: begin
            end
          endcase
          phase_next = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      pend     <= 1'b0;
      hold_cnt <= '0;
      win_cnt  <= '0;
    end else begin
      phase    <= phase_next;
      pend     <= pend_next;
      hold_cnt <= hold_cnt_next;
      win_cnt  <= win_cnt_next;
    end
  end

  // A running double-press window always belongs to a pending double.
  a_window_needs_pending: assert property (@(posedge clk) disable iff (rst)
    (win_cnt != '0) |-> pend)
    else $error("double window running without pending double");

endmodule

/* hw/rtl/bgc_event_queue.sv */
// Holds the events of one input and sends them one per cycle through the output register while out_ready is high.
// Depends on bgc_pkg for out_item_t and the slot count.
module bgc_event_queue
  import bgc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic [NSLOT-1:0] slot_valid,
  input  out_item_t        slot_item [NSLOT],
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item
);

  logic [NSLOT-1:0] mask, mask_next, mask_after_pop;
  logic [NSLOT-1:0] pick_onehot;
  logic [NSLOT-1:0] last_flag;
  out_item_t        group_item [NSLOT];
  out_item_t        pick;
  logic             out_load;

  assign pick_onehot    = mask & (~mask + 1'b1);
  assign out_load       = (mask != '0) && (!out_valid || out_ready);
  assign mask_after_pop = out_load ? (mask & ~pick_onehot) : mask;
  assign free           = (mask_after_pop == '0);
  assign mask_next      = load ? slot_valid : mask_after_pop;

  always_comb begin
    pick = '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (pick_onehot[i]) begin
        pick = group_item[i];
      end
    end
  end

  // The highest present slot carries the end-of-run mark.
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      last_flag[i] = slot_valid[i] && !seen;
      seen         = seen || slot_valid[i];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < NSLOT; i++) begin
        group_item[i].button_index <= slot_item[i].button_index;
        group_item[i].event_kind   <= slot_item[i].event_kind;
        group_item[i].last_of_run  <= last_flag[i];
      end
    end
    if (out_load) begin
      out_item <= pick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask      <= '0;
      out_valid <= 1'b0;
    end else begin
      mask <= mask_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_last_empties_group: assert property (@(posedge clk) disable iff (rst)
    (out_load && pick.last_of_run) |-> (mask_after_pop == '0))
    else $error("end-of-run event sent while the group still holds events");

  a_stall_keeps_group: assert property (@(posedge clk) disable iff (rst)
    (mask != '0 && out_valid && !out_ready) |=> $stable(mask))
    else $error("event group changed while the output was stalled");

endmodule

/* hw/rtl/button_gesture_classifier_core.sv */
// Top level of the two-button gesture classifier: input register, debounce logic,
// per-button units and the event queue. Depends on bgc_pkg and all bgc_* modules.
//
// Usage:
//   in_item (cmd, pin_levels) is a valid/ready channel. cmd = tick advances all
//   countdowns by one; cmd = edge captures pin_levels and restarts the debounce
//   countdown. Each accepted item yields zero to four events on the out_item
//   valid/ready channel, in order, the last one flagged by last_of_run.
//   The first event of an item passes from the input register through the event
//   group into the output register. The whole update of an item is done
//   combinationally between the input register and the event group; events then
//   leave one per cycle, and items with no events flow at one per cycle.
//   When the receiver stalls, the output register and the event group hold,
//   the input register fills and in_ready drops; nothing is lost.
//   Synchronous reset (rst) releases all buttons, stops every countdown and
//   loads the configuration defaults. cfg_we writes cfg_data to the register at
//   cfg_index in the same edge; write only while the block is idle.
module button_gesture_classifier_core
  import bgc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_item,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t             cfg;
  in_item_t         inq;
  logic             inq_valid;
  logic             free;
  logic             proc_fire;
  logic             tick;

  logic [DEB_W-1:0]   deb_cnt, deb_cnt_next;
  logic [LEVEL_W-1:0] capture, capture_next;
  logic [LEVEL_W-1:0] stable, stable_next;
  logic [LEVEL_W-1:0] changed;
  logic [DEB_W-1:0]   deb_dec;
  logic               deb_exp;

  btn_ev_t          btn_ev [BUTTONS];
  logic [NSLOT-1:0] slot_valid;
  out_item_t        slot_item [NSLOT];

  bgc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign proc_fire = inq_valid && free;
  assign in_ready  = !inq_valid || proc_fire;
  assign tick      = proc_fire && (inq.cmd == CMD_TICK);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      inq_valid <= 1'b1;
    end else if (proc_fire) begin
      inq_valid <= 1'b0;
    end
  end

  // A button counts as changed only if its level still matches the edge capture.
  assign deb_dec = deb_cnt - 1'b1;
  assign deb_exp = tick && (deb_cnt != '0) && (deb_dec == '0);
  assign changed = deb_exp ? ((inq.pin_levels ^ stable) & ~(inq.pin_levels ^ capture)) : '0;

  always_comb begin
    deb_cnt_next = deb_cnt;
    capture_next = capture;
    stable_next  = stable;
    if (proc_fire && inq.cmd == CMD_EDGE) begin
      capture_next = inq.pin_levels;
      deb_cnt_next = cfg.debounce_ticks;
    end else if (tick && deb_cnt != '0) begin
      deb_cnt_next = deb_dec;
      if (deb_exp) begin
        stable_next = inq.pin_levels;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deb_cnt <= '0;
      capture <= '1;
      stable  <= '1;
    end else begin
      deb_cnt <= deb_cnt_next;
      capture <= capture_next;
      stable  <= stable_next;
    end
  end

  for (genvar b = 0; b < BUTTONS; b++) begin : g_btn
    bgc_button u_btn (
      .clk  (clk),
      .rst  (rst),
      .tick (tick),
      .chg  (changed[b]),
      .lvl  (inq.pin_levels[b]),
      .cfg  (cfg),
      .ev   (btn_ev[b])
    );

    // Timer events of all buttons come first, then the release events.
    assign slot_valid[2*b]                   = btn_ev[b].hold_ev;
    assign slot_item[2*b].button_index       = BTN_W'(b);
    assign slot_item[2*b].event_kind         = btn_ev[b].hold_kind;
    assign slot_item[2*b].last_of_run        = 1'b0;
    assign slot_valid[2*b+1]                 = btn_ev[b].win_ev;
    assign slot_item[2*b+1].button_index     = BTN_W'(b);
    assign slot_item[2*b+1].event_kind       = EV_SHORT;
    assign slot_item[2*b+1].last_of_run      = 1'b0;
    assign slot_valid[2*BUTTONS+b]             = btn_ev[b].rel_ev;
    assign slot_item[2*BUTTONS+b].button_index = BTN_W'(b);
    assign slot_item[2*BUTTONS+b].event_kind   = btn_ev[b].rel_kind;
    assign slot_item[2*BUTTONS+b].last_of_run  = 1'b0;
  end

  bgc_event_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .load       (proc_fire),
    .slot_valid (slot_valid),
    .slot_item  (slot_item),
    .free       (free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

  a_confirm_levels: assert property (@(posedge clk) disable iff (rst)
    deb_exp |=> (stable == $past(inq.pin_levels)))
    else $error("confirmed levels not taken at debounce expiry");

endmodule

/* tb/tb_button_gesture_classifier_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench for button_gesture_classifier_core: directed gestures,
// register extremes, back-pressure and random traffic against a built-in predictor.
// Depends on bgc_pkg and the RTL under hw/rtl.
module tb_button_gesture_classifier_core;
  import bgc_pkg::*;

  localparam int MAX_EVENTS    = 6;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 1000;
  localparam int LONG_STALL    = 150;
  localparam int RANDOM_ITEMS  = 150;

  typedef enum logic [1:0] {PH_IDLE, PH_SHORT, PH_LONG, PH_VLONG} phase_t;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_item_t               in_item   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_item;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_LONG_HOLD;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // Predicted block state and configuration.
  cfg_t                cur_cfg;
  phase_t              btn_phase        [BUTTONS];
  logic                double_armed     [BUTTONS];
  logic [HOLD_W-1:0]   hold_left        [BUTTONS];
  logic [HOLD_W-1:0]   window_left      [BUTTONS];
  logic [DEB_W-1:0]    debounce_left;
  logic [LEVEL_W-1:0]  edge_levels;
  logic [LEVEL_W-1:0]  confirmed_levels;

  out_item_t step_events[$];
  out_item_t pending_events[$];

  logic [LEVEL_W-1:0] pins = '1;
  bit tx_gaps_on     = 1'b1;
  bit rx_gaps_on     = 1'b1;
  bit long_stall_req = 1'b0;
  int mismatches     = 0;
  int items_sent     = 0;
  int events_checked = 0;
  int settings_used  = 0;
  int quiet_cycles   = 0;

  button_gesture_classifier_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void add_event(int b, logic [KIND_W-1:0] kind);
    out_item_t ev;
    ev.button_index = BTN_W'(b);
    ev.event_kind   = kind;
    ev.last_of_run  = 1'b0;
    if (step_events.size() < MAX_EVENTS) step_events.push_back(ev);
  endfunction

  // Applies one accepted input to the predicted state and queues the events it raises.
  function automatic void classify_input(in_item_t it);
    logic [LEVEL_W-1:0] lv;
    logic [LEVEL_W-1:0] agree;
    logic [LEVEL_W-1:0] changed;
    lv = it.pin_levels;
    step_events.delete();
    if (it.cmd == CMD_EDGE) begin
      edge_levels   = lv;
      debounce_left = cur_cfg.debounce_ticks;
      return;
    end
    for (int b = 0; b < BUTTONS; b++) begin
      if (hold_left[b] != 0) begin
        hold_left[b]--;
        if (hold_left[b] == 0) begin
          if (btn_phase[b] == PH_SHORT) begin
            add_event(b, EV_LONG_HOLD);
            hold_left[b] = cur_cfg.very_long_extra_ticks;
            btn_phase[b] = PH_LONG;
          end else if (btn_phase[b] == PH_LONG) begin
            add_event(b, EV_VLONG_HOLD);
            btn_phase[b] = PH_VLONG;
          end
        end
      end
      if (window_left[b] != 0) begin
        window_left[b]--;
        if (window_left[b] == 0) begin
          double_armed[b] = 1'b0;
          btn_phase[b]    = PH_IDLE;
          add_event(b, EV_SHORT);
        end
      end
    end
    if (debounce_left != 0) begin
      debounce_left--;
      if (debounce_left == 0) begin
        // Only bits that still match the captured edge may count as a change.
        agree   = ~(lv ^ edge_levels);
        changed = (lv ^ confirmed_levels) & agree;
        confirmed_levels = lv;
        for (int b = 0; b < BUTTONS; b++) begin
          if (changed[b]) begin
            hold_left[b] = '0;
            if (!lv[b]) begin
              if (btn_phase[b] != PH_SHORT) begin
                btn_phase[b] = PH_SHORT;
                hold_left[b] = cur_cfg.long_hold_ticks;
              end
            end else begin
              case (btn_phase[b])
                PH_SHORT: begin
                  if (!double_armed[b]) begin
                    double_armed[b] = 1'b1;
                    window_left[b]  = cur_cfg.double_window_ticks;
                  end else begin
                    double_armed[b] = 1'b0;
                    window_left[b]  = '0;
                    add_event(b, EV_DOUBLE);
                  end
                end
                PH_LONG:  add_event(b, EV_LONG_PRESS);
                PH_VLONG: add_event(b, EV_VLONG_PRESS);
                default: ;
              endcase
              btn_phase[b] = PH_IDLE;
            end
          end
        end
      end
    end
    if (step_events.size() > 0) step_events[step_events.size()-1].last_of_run = 1'b1;
    foreach (step_events[i]) pending_events.push_back(step_events[i]);
  endfunction

  always @(posedge clk) begin : check_events
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected event: button %0d kind %0d last %0d", $time,
                 out_item.button_index, out_item.event_kind, out_item.last_of_run);
      end else begin
        want = pending_events.pop_front();
        events_checked++;
        if (out_item.button_index !== want.button_index ||
            out_item.event_kind !== want.event_kind ||
            out_item.last_of_run !== want.last_of_run) begin
          mismatches++;
          $display("%0t: event mismatch: expected button %0d kind %0d last %0d, got %0d %0d %0d",
                   $time, want.button_index, want.event_kind, want.last_of_run,
                   out_item.button_index, out_item.event_kind, out_item.last_of_run);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d events outstanding", $time,
               quiet_cycles, pending_events.size());
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random short stalls, occasional long ones, and a requested hold-off.
  initial begin : ready_driver
    int stall_left;
    int r;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        stall_left     = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!rx_gaps_on) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 97) begin
          out_ready <= (r < 75);
        end else begin
          stall_left = $urandom_range(10, 40);
          out_ready <= 1'b0;
        end
      end
    end
  end

  task automatic send_item(logic cmd, logic [LEVEL_W-1:0] levels);
    in_item_t it;
    int gap;
    int r;
    it.cmd        = cmd;
    it.pin_levels = levels;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    classify_input(it);
    items_sent++;
    gap = 0;
    if (tx_gaps_on) begin
      r = $urandom_range(0, 99);
      if (r >= 95) gap = $urandom_range(8, 30);
      else if (r >= 65) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic tick_n(int n);
    repeat (n) send_item(CMD_TICK, pins);
  endtask

  task automatic move_pins(logic [LEVEL_W-1:0] lv);
    pins = lv;
    send_item(CMD_EDGE, pins);
  endtask

  task automatic press_release(logic [LEVEL_W-1:0] mask, int held);
    move_pins(pins & ~mask);
    tick_n(cur_cfg.debounce_ticks + held);
    move_pins(pins | mask);
    tick_n(cur_cfg.debounce_ticks);
  endtask

  // The sender stops until every predicted event has arrived and the pipeline is empty.
  task automatic drain_events();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic set_config(logic [HOLD_W-1:0] hold, logic [HOLD_W-1:0] vlong,
                            logic [HOLD_W-1:0] window, logic [DEB_W-1:0] deb);
    drain_events();
    put_reg(REG_LONG_HOLD, hold);
    put_reg(REG_VLONG_EXTRA, vlong);
    put_reg(REG_DOUBLE_WINDOW, window);
    put_reg(REG_DEBOUNCE, CFG_DATA_W'(deb));
    cfg_we <= 1'b0;
    cur_cfg.long_hold_ticks       = hold;
    cur_cfg.very_long_extra_ticks = vlong;
    cur_cfg.double_window_ticks   = window;
    cur_cfg.debounce_ticks        = deb;
    settings_used++;
  endtask

  task automatic test_basic_gestures();
    set_config(16'd2, 16'd2, 16'd2, 8'd1);
    press_release(2'b01, 0);
    tick_n(3);
    press_release(2'b10, 0);
    press_release(2'b10, 0);
    press_release(2'b01, 3);
    press_release(2'b11, 5);
    press_release(2'b11, 0);
    tick_n(3);
  endtask

  // A release that is not confirmed still updates the stable levels, so the next
  // confirmed push lands while the button is already in its short phase.
  task automatic test_push_in_short_phase();
    set_config(16'd8, 16'd3, 16'd2, 8'd2);
    move_pins(2'b10);
    tick_n(2);
    send_item(CMD_EDGE, 2'b10);
    send_item(CMD_TICK, 2'b11);
    send_item(CMD_TICK, 2'b11);
    send_item(CMD_EDGE, 2'b10);
    tick_n(12);
    move_pins(2'b11);
    tick_n(5);
  endtask

  // The long debounce load is superseded by a new edge before it runs out.
  task automatic test_register_extremes();
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    move_pins(2'b10);
    tick_n(8);
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd1);
    move_pins(2'b11);
    tick_n(1);
    press_release(2'b01, 3);
    set_config(16'd1, 16'd1, 16'd1, 8'd1);
    press_release(2'b11, 0);
    tick_n(1);
    press_release(2'b01, 3);
  endtask

  // A register value of zero leaves the matching countdown stopped.
  task automatic test_zero_registers();
    set_config(16'd0, 16'd0, 16'd2, 8'd1);
    press_release(2'b01, 3);
    tick_n(3);
    set_config(16'd2, 16'd0, 16'd0, 8'd1);
    press_release(2'b10, 5);
    press_release(2'b01, 0);
    tick_n(4);
    press_release(2'b01, 0);
    set_config(16'd2, 16'd2, 16'd2, 8'd0);
    move_pins(2'b00);
    tick_n(5);
    move_pins(2'b11);
    tick_n(2);
  endtask

  task automatic test_backpressure();
    set_config(16'd1, 16'd1, 16'd1, 8'd1);
    long_stall_req = 1'b1;
    while (long_stall_req) @(posedge clk);
    repeat (6) begin
      move_pins(2'b00);
      tick_n(4);
      move_pins(2'b11);
      tick_n(1);
    end
    drain_events();
  endtask

  task automatic test_random_traffic();
    int start;
    int next_cfg;
    int r;
    logic [LEVEL_W-1:0] nxt;
    start    = items_sent;
    next_cfg = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      if (items_sent - start >= next_cfg) begin
        set_config(HOLD_W'($urandom_range(1, 8)), HOLD_W'($urandom_range(1, 8)),
                   HOLD_W'($urandom_range(1, 6)), DEB_W'($urandom_range(1, 4)));
        tx_gaps_on = ($urandom_range(0, 3) != 0);
        rx_gaps_on = ($urandom_range(0, 3) != 0);
        next_cfg  += 50;
      end
      r = $urandom_range(0, 99);
      if (r < 70) begin
        do nxt = LEVEL_W'($urandom_range(0, 3)); while (nxt == pins);
        move_pins(nxt);
        if ($urandom_range(0, 1))
          tick_n(cur_cfg.debounce_ticks + $urandom_range(0, 3));
        else
          tick_n(cur_cfg.debounce_ticks + $urandom_range(0, cur_cfg.long_hold_ticks +
                 cur_cfg.very_long_extra_ticks + 2));
      end else if (r < 90) begin
        // Contact bounce and ticks that read levels other than the captured ones.
        repeat ($urandom_range(1, 4))
          send_item(logic'($urandom_range(0, 1)), LEVEL_W'($urandom_range(0, 3)));
        move_pins(pins);
      end else begin
        tick_n($urandom_range(1, 8));
      end
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  initial begin
    cur_cfg.long_hold_ticks       = LONG_HOLD_RESET;
    cur_cfg.very_long_extra_ticks = VLONG_EXTRA_RESET;
    cur_cfg.double_window_ticks   = DOUBLE_WINDOW_RESET;
    cur_cfg.debounce_ticks        = DEBOUNCE_RESET;
    for (int b = 0; b < BUTTONS; b++) begin
      btn_phase[b]    = PH_IDLE;
      double_armed[b] = 1'b0;
      hold_left[b]    = '0;
      window_left[b]  = '0;
    end
    debounce_left    = '0;
    edge_levels      = '1;
    confirmed_levels = '1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_gestures();
    test_push_in_short_phase();
    test_register_extremes();
    test_zero_registers();
    test_backpressure();
    test_random_traffic();
    drain_events();
    repeat (20) @(posedge clk);
    if (pending_events.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected events never arrived", $time, pending_events.size());
    end
    $display("Sent %0d input items under %0d register settings, checked %0d events.",
             items_sent, settings_used, events_checked);
    $display("Covered all gesture kinds, zero and maximum registers, and a long output stall.");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
